/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They are clocked on clk_i and are off
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SFMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define SFMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sfmp_pkg.sv */
// ----------------------------------------------------------------------------
// Frame parser package
// Byte codes, parse positions, result kinds, frame classes and the result
// record shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfmp_pkg;

  // Framing bytes.
  localparam logic [7:0] SYNC_A     = 8'h3C;
  localparam logic [7:0] SYNC_B     = 8'h7B;
  localparam logic [7:0] SYNC_C     = 8'h28;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] ID_REQUEST = 8'd254;
  localparam logic [7:0] ID_ACK     = 8'd255;

  // Parse positions.
  localparam logic [3:0] P_HUNT_A  = 4'd0;
  localparam logic [3:0] P_HUNT_B  = 4'd1;
  localparam logic [3:0] P_HUNT_C  = 4'd2;
  localparam logic [3:0] P_ID      = 4'd3;
  localparam logic [3:0] P_INST_LO = 4'd4;
  localparam logic [3:0] P_INST_HI = 4'd5;
  localparam logic [3:0] P_LEN     = 4'd6;
  localparam logic [3:0] P_BODY    = 4'd7;
  localparam logic [3:0] P_CR      = 4'd8;
  localparam logic [3:0] P_LF      = 4'd9;

  // Result kinds.
  localparam logic [1:0] KIND_BODY   = 2'd0;
  localparam logic [1:0] KIND_COMMIT = 2'd1;
  localparam logic [1:0] KIND_ABORT  = 2'd2;

  // Frame classes.
  localparam logic [1:0] CLASS_DATA    = 2'd0;
  localparam logic [1:0] CLASS_REQUEST = 2'd1;
  localparam logic [1:0] CLASS_ACK     = 2'd2;

  // One result record as it leaves the parser.
  typedef struct packed {
    logic        valid;
    logic [1:0]  result_kind;
    logic [7:0]  body_byte;
    logic [7:0]  body_position;
    logic [7:0]  message_id;
    logic [15:0] instance_number;
    logic [7:0]  body_size;
    logic [1:0]  frame_class;
    logic [31:0] data_frames_seen;
  } res_t;

  // Class of a frame from its id byte.
  function automatic logic [1:0] class_of(input logic [7:0] id);
    logic [1:0] cls;
    if (id == ID_REQUEST) begin
      cls = CLASS_REQUEST;
    end else if (id == ID_ACK) begin
      cls = CLASS_ACK;
    end else begin
      cls = CLASS_DATA;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sfmp_if.sv */
// ----------------------------------------------------------------------------
// Frame parser channels
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
`default_nettype none

// Received byte channel.
interface sfmp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Parser result channel.
interface sfmp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  body_byte;
  logic [7:0]  body_position;
  logic [7:0]  message_id;
  logic [15:0] instance_number;
  logic [7:0]  body_size;
  logic [1:0]  frame_class;
  logic [31:0] data_frames_seen;

  modport source (
    output valid, output result_kind, output body_byte, output body_position,
    output message_id, output instance_number, output body_size,
    output frame_class, output data_frames_seen, input ready
  );
  modport sink (
    input valid, input result_kind, input body_byte, input body_position,
    input message_id, input instance_number, input body_size,
    input frame_class, input data_frames_seen, output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/sync_framed_message_parser_top.sv */
// ----------------------------------------------------------------------------
// Framed message parser, top level
// Received bytes come in on rx_i, one per transfer. The block hunts for the
// sync bytes '<' '{' '(' and then reads id, instance (low byte first) and
// length, passes each body byte on at once, and ends the frame with a commit
// result on CR LF or an abort result otherwise. A commit carries the frame
// class and the running count of committed data frames.
// Results leave on res_o, at most one per received byte; header and sync
// bytes give none.
// A byte in the input register is parsed when the result register is free,
// and its result is then loaded into the result register, where res_o.valid
// rises and the result waits to be taken.
// Throughput: one byte per cycle while the receiver takes the results, set by
// the single parse step between the input register and the result register.
// Reset clears the parse position, the held header fields and the counters;
// the block then hunts for the first sync byte.
// When the receiver stalls, the result is held, one more byte waits in the
// input register, and rx_i.ready then drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_framed_message_parser_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  sfmp_rx_if.sink     rx_i,
  sfmp_res_if.source  res_o
);

  import sfmp_pkg::*;

  logic       in_vld;
  logic [7:0] in_byte;
  logic       out_free;
  logic       step;
  res_t       step_res;

  // The parser consumes the held byte whenever the result register is free.
  assign step = in_vld && out_free;

  sfmp_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .take_i (step),
    .vld_o  (in_vld),
    .byte_o (in_byte)
  );

  sfmp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte),
    .res_o  (step_res)
  );

  sfmp_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step && step_res.valid),
    .res_i  (step_res),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/sfmp_in_stage.sv */
// ----------------------------------------------------------------------------
// Frame parser input register
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmp_in_stage (
  input  wire         clk_i,
  input  wire         rst_ni,
  sfmp_rx_if.sink     rx_i,
  input  wire         take_i,
  output logic        vld_o,
  output logic [7:0]  byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       load;

  // A new transfer is taken when the register is empty or drains this cycle.
  assign rx_i.ready = !vld_q || take_i;
  assign load       = rx_i.valid && rx_i.ready;
  assign vld_d      = load || (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

`default_nettype wire

/* hw/rtl/sfmp_parser.sv */
// ----------------------------------------------------------------------------
// Frame parser step
// Parse position, held header fields and counters, with the one-byte step
// logic that yields at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sfmp_parser (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              step_i,
  input  wire [7:0]        byte_i,
  output sfmp_pkg::res_t   res_o
);

  import sfmp_pkg::*;

  logic [3:0]  pos_q, pos_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] inst_q, inst_d;
  logic [7:0]  len_q, len_d;
  logic [8:0]  bcnt_q, bcnt_d;
  logic [31:0] frame_q, frame_d;
  logic [1:0]  cls;
  logic        commit_data;

  assign cls = class_of(id_q);

  // Next state and result for the byte at hand.
  always_comb begin
    pos_d       = pos_q;
    id_d        = id_q;
    inst_d      = inst_q;
    len_d       = len_q;
    bcnt_d      = bcnt_q;
    frame_d     = frame_q;
    commit_data = 1'b0;
    res_o.valid       = 1'b0;
    res_o.result_kind = KIND_BODY;
    res_o.body_byte   = 8'h00;
    res_o.body_position = 8'h00;
    case (pos_q)
      P_HUNT_A: begin
        if (byte_i == SYNC_A) begin
          pos_d = P_HUNT_B;
        end else begin
          pos_d  = P_HUNT_A;
          bcnt_d = 9'd0;
        end
      end
      P_HUNT_B: begin
        if (byte_i == SYNC_B) begin
          pos_d = P_HUNT_C;
        end else begin
          pos_d  = P_HUNT_A;
          bcnt_d = 9'd0;
        end
      end
      P_HUNT_C: begin
        if (byte_i == SYNC_C) begin
          pos_d = P_ID;
        end else begin
          pos_d  = P_HUNT_A;
          bcnt_d = 9'd0;
        end
      end
      P_ID: begin
        id_d  = byte_i;
        pos_d = P_INST_LO;
      end
      P_INST_LO: begin
        inst_d = {8'h00, byte_i};
        pos_d  = P_INST_HI;
      end
      P_INST_HI: begin
        inst_d = {byte_i, inst_q[7:0]};
        pos_d  = P_LEN;
      end
      P_LEN: begin
        len_d  = byte_i;
        bcnt_d = 9'd0;
        pos_d  = P_BODY;
      end
      P_BODY: begin
        // A zero length still takes one body byte.
        bcnt_d = bcnt_q + 9'd1;
        if (bcnt_d >= {1'b0, len_q}) begin
          pos_d = P_CR;
        end
        res_o.valid         = 1'b1;
        res_o.result_kind   = KIND_BODY;
        res_o.body_byte     = byte_i;
        res_o.body_position = bcnt_q[7:0];
      end
      P_CR: begin
        if (byte_i == BYTE_CR) begin
          pos_d = P_LF;
        end else begin
          pos_d             = P_HUNT_A;
          bcnt_d            = 9'd0;
          res_o.valid       = 1'b1;
          res_o.result_kind = KIND_ABORT;
        end
      end
      P_LF: begin
        pos_d       = P_HUNT_A;
        bcnt_d      = 9'd0;
        res_o.valid = 1'b1;
        if (byte_i == BYTE_LF) begin
          res_o.result_kind = KIND_COMMIT;
          if (cls == CLASS_DATA) begin
            commit_data = 1'b1;
            frame_d     = frame_q + 32'd1;
          end
        end else begin
          res_o.result_kind = KIND_ABORT;
        end
      end
      default: begin
        pos_d  = P_HUNT_A;
        bcnt_d = 9'd0;
      end
    endcase
    // Header fields come from the held values; the count includes this commit.
    res_o.message_id       = id_q;
    res_o.instance_number  = inst_q;
    res_o.body_size        = len_q;
    res_o.frame_class      = cls;
    res_o.data_frames_seen = frame_d;
  end

  // Parser state advances only on a byte the step consumes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= P_HUNT_A;
      id_q    <= 8'h00;
      inst_q  <= 16'h0000;
      len_q   <= 8'h00;
      bcnt_q  <= 9'd0;
      frame_q <= 32'd0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      id_q    <= id_d;
      inst_q  <= inst_d;
      len_q   <= len_d;
      bcnt_q  <= bcnt_d;
      frame_q <= frame_d;
    end
  end

  // The body count never runs past one more than the largest length.
  `SFMP_ASSERT(a_bcnt_range, bcnt_q <= 9'd256, "body count out of range")
  // Waiting for CR means the whole body has been taken.
  `SFMP_ASSERT_IMP(a_cr_after_body, pos_q == P_CR, bcnt_q >= {1'b0, len_q}, "CR wait early")
  // The data frame count moves only on a consumed commit of a data frame.
  `SFMP_ASSERT_IMP(a_frame_cnt, !$stable(frame_q), $past(step_i && commit_data), "stray count")

endmodule

`default_nettype wire

/* hw/rtl/sfmp_out_stage.sv */
// ----------------------------------------------------------------------------
// Frame parser result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmp_out_stage (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             load_i,
  input  sfmp_pkg::res_t  res_i,
  output logic            free_o,
  sfmp_res_if.source      res_o
);

  import sfmp_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;

  // The register can take a new result when empty or drained this cycle.
  assign free_o = !vld_q || res_o.ready;
  assign vld_d  = free_o ? load_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid            = vld_q;
  assign res_o.result_kind      = res_q.result_kind;
  assign res_o.body_byte        = res_q.body_byte;
  assign res_o.body_position    = res_q.body_position;
  assign res_o.message_id       = res_q.message_id;
  assign res_o.instance_number  = res_q.instance_number;
  assign res_o.body_size        = res_q.body_size;
  assign res_o.frame_class      = res_q.frame_class;
  assign res_o.data_frames_seen = res_q.data_frames_seen;

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed message parser testbench
// Streams received bytes into the parser: a short directed opening, then
// random frames mixed with line noise and broken frames. Every accepted
// byte runs through a local deframer, and each result transfer is checked
// field by field against the oldest predicted result. Both channels idle
// and stall at random, with long receiver hold-offs and drain pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import sfmp_pkg::*;

  // Idle cycles without any transfer before the run is declared hung. The
  // longest correct quiet stretch is one receiver hold-off plus a sender gap.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_BYTES = 950;

  typedef enum {END_CLEAN, END_NO_CR, END_BAD_LF} frame_end_e;

  // One byte to send; drain_first holds it back until all results are in.
  typedef struct {
    logic [7:0] value;
    bit         drain_first;
  } rx_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  body_byte;
    logic [7:0]  body_pos;
    logic [7:0]  msg_id;
    logic [15:0] inst;
    logic [7:0]  size;
    logic [1:0]  cls;
    logic [31:0] data_count;
  } frame_result_t;

  logic clk_i;
  logic rst_n;

  sfmp_rx_if  rx_ch ();
  sfmp_res_if res_ch ();

  sync_framed_message_parser_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  rx_item_t      rx_stream[$];
  frame_result_t results_due[$];

  // Deframer state, mirrored from the block.
  logic [3:0]  parse_pos;
  logic [7:0]  held_id;
  logic [15:0] held_inst;
  logic [7:0]  held_len;
  logic [8:0]  body_cnt;
  logic [31:0] data_frames;

  int unsigned results_predicted;
  int unsigned results_checked;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned frames_queued;
  int unsigned random_bytes_queued;
  int unsigned body_seen, commits_seen, aborts_seen;
  int unsigned burst_left, gap_left;
  int unsigned hold_left, holds_done, ready_cycle;
  int unsigned idle_cycles;

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [1:0] id_to_class(input logic [7:0] id);
    case (id)
      ID_REQUEST: return CLASS_REQUEST;
      ID_ACK:     return CLASS_ACK;
      default:    return CLASS_DATA;
    endcase
  endfunction

  function automatic frame_result_t frame_result(input logic [1:0] kind,
                                                 input logic [7:0] b,
                                                 input logic [7:0] pos);
    frame_result_t r;
    r.kind       = kind;
    r.body_byte  = b;
    r.body_pos   = pos;
    r.msg_id     = held_id;
    r.inst       = held_inst;
    r.size       = held_len;
    r.cls        = id_to_class(held_id);
    r.data_count = data_frames;
    return r;
  endfunction

  // Steps the deframer by one received byte and queues the result it causes.
  task automatic deframe_byte(input logic [7:0] b);
    logic [8:0] pos;
    pos = body_cnt;
    case (parse_pos)
      P_HUNT_A: begin
        if (b == SYNC_A) parse_pos = P_HUNT_B;
        else body_cnt = '0;
      end
      P_HUNT_B: begin
        if (b == SYNC_B) parse_pos = P_HUNT_C;
        else begin
          parse_pos = P_HUNT_A;
          body_cnt  = '0;
        end
      end
      P_HUNT_C: begin
        if (b == SYNC_C) parse_pos = P_ID;
        else begin
          parse_pos = P_HUNT_A;
          body_cnt  = '0;
        end
      end
      P_ID: begin
        held_id   = b;
        parse_pos = P_INST_LO;
      end
      P_INST_LO: begin
        held_inst = {8'h00, b};
        parse_pos = P_INST_HI;
      end
      P_INST_HI: begin
        held_inst[15:8] = b;
        parse_pos       = P_LEN;
      end
      P_LEN: begin
        held_len  = b;
        body_cnt  = '0;
        parse_pos = P_BODY;
      end
      P_BODY: begin
        // A zero length still takes one body byte.
        body_cnt = body_cnt + 9'd1;
        if (body_cnt >= {1'b0, held_len}) parse_pos = P_CR;
        results_due.push_back(frame_result(KIND_BODY, b, pos[7:0]));
        results_predicted++;
      end
      P_CR: begin
        if (b == BYTE_CR) parse_pos = P_LF;
        else begin
          // The byte standing in for the CR is dropped.
          parse_pos = P_HUNT_A;
          body_cnt  = '0;
          results_due.push_back(frame_result(KIND_ABORT, 8'h00, 8'h00));
          results_predicted++;
        end
      end
      P_LF: begin
        parse_pos = P_HUNT_A;
        body_cnt  = '0;
        if (b == BYTE_LF) begin
          if (id_to_class(held_id) == CLASS_DATA) data_frames = data_frames + 32'd1;
          results_due.push_back(frame_result(KIND_COMMIT, 8'h00, 8'h00));
        end else begin
          results_due.push_back(frame_result(KIND_ABORT, 8'h00, 8'h00));
        end
        results_predicted++;
      end
      default: begin
        parse_pos = P_HUNT_A;
        body_cnt  = '0;
      end
    endcase
  endtask

  task automatic add_byte(input logic [7:0] value, input bit drain_first);
    rx_item_t item;
    item.value       = value;
    item.drain_first = drain_first;
    rx_stream.push_back(item);
  endtask

  // Queues one frame with a random body; tail_byte replaces the CR or the LF
  // when the frame is to be broken.
  task automatic add_frame(input logic [7:0] id, input logic [15:0] inst,
                           input logic [7:0] len, input frame_end_e ending,
                           input logic [7:0] tail_byte, input bit drain_first);
    int n;
    n = (len == 8'd0) ? 1 : int'(len);
    add_byte(SYNC_A, drain_first);
    add_byte(SYNC_B, 1'b0);
    add_byte(SYNC_C, 1'b0);
    add_byte(id, 1'b0);
    add_byte(inst[7:0], 1'b0);
    add_byte(inst[15:8], 1'b0);
    add_byte(len, 1'b0);
    for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)), 1'b0);
    case (ending)
      END_CLEAN: begin
        add_byte(BYTE_CR, 1'b0);
        add_byte(BYTE_LF, 1'b0);
      end
      END_NO_CR: add_byte(tail_byte, 1'b0);
      default: begin
        add_byte(BYTE_CR, 1'b0);
        add_byte(tail_byte, 1'b0);
      end
    endcase
    frames_queued++;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Sender: records accepted transfers, then offers the next byte in bursts.
  always @(posedge clk_i) begin
    rx_item_t item;
    if (rst_n) begin
      if (rx_ch.valid && rx_ch.ready) begin
        deframe_byte(rx_ch.rx_byte);
        bytes_sent++;
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          rx_ch.valid <= 1'b0;
        end else if (rx_stream.size() > 0 &&
                     !(rx_stream[0].drain_first && results_predicted != results_checked)) begin
          item = rx_stream.pop_front();
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= item.value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: shifting stall patterns, plus two long hold-offs mid-run.
  always @(posedge clk_i) begin
    if (rst_n) begin
      ready_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (holds_done < 2 && results_checked >= 100 + 300 * holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        case (ready_cycle[9:7])
          3'd2:    res_ch.ready <= 1'($urandom_range(0, 1));
          3'd3:    res_ch.ready <= ($urandom_range(0, 3) == 0);
          3'd4:    res_ch.ready <= ready_cycle[2];
          3'd5:    res_ch.ready <= ($urandom_range(0, 7) != 0);
          default: res_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("result transfer with no result predicted (kind %0d)", res_ch.result_kind);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(res_ch.result_kind));
        check_field("body_byte", 32'(want.body_byte), 32'(res_ch.body_byte));
        check_field("body_position", 32'(want.body_pos), 32'(res_ch.body_position));
        check_field("message_id", 32'(want.msg_id), 32'(res_ch.message_id));
        check_field("instance_number", 32'(want.inst), 32'(res_ch.instance_number));
        check_field("body_size", 32'(want.size), 32'(res_ch.body_size));
        check_field("frame_class", 32'(want.cls), 32'(res_ch.frame_class));
        check_field("data_frames_seen", want.data_count, res_ch.data_frames_seen);
        case (want.kind)
          KIND_BODY:   body_seen++;
          KIND_COMMIT: commits_seen++;
          default:     aborts_seen++;
        endcase
        results_checked <= results_checked + 1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [7:0]  id, len, tail;
    frame_end_e  ending;
    int unsigned pick, before_cnt;
    bit          big_done;

    rst_n = 1'b0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    res_ch.ready = 1'b0;
    parse_pos = P_HUNT_A;
    held_id = '0;
    held_inst = '0;
    held_len = '0;
    body_cnt = '0;
    data_frames = '0;
    results_predicted = 0;
    results_checked = 0;
    errors = 0;
    bytes_sent = 0;
    frames_queued = 0;
    random_bytes_queued = 0;
    body_seen = 0;
    commits_seen = 0;
    aborts_seen = 0;
    burst_left = 0;
    gap_left = 0;
    hold_left = 0;
    holds_done = 0;
    ready_cycle = 0;
    idle_cycles = 0;
    big_done = 1'b0;

    // Directed opening. A second '<' in place of '{' is not taken as a new
    // first sync byte, so the following '{' is noise as well.
    add_byte(SYNC_A, 1'b0);
    add_byte(SYNC_A, 1'b0);
    add_byte(SYNC_B, 1'b0);
    // Data frame with zero length, all-zero header, clean end.
    add_frame(8'h00, 16'h0000, 8'd0, END_CLEAN, 8'h00, 1'b0);
    // Ack frame with maximum instance; a sync byte where the CR belongs.
    add_frame(ID_ACK, 16'hFFFF, 8'd1, END_NO_CR, SYNC_A, 1'b0);
    // Request frame; the byte after the CR is not an LF.
    add_frame(ID_REQUEST, 16'h8001, 8'd1, END_BAD_LF, BYTE_CR, 1'b0);

    // Random part: mostly well-formed frames, some noise and broken frames.
    while (random_bytes_queued < RANDOM_BYTES) begin
      before_cnt = rx_stream.size();
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        case ($urandom_range(0, 2))
          0: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)), 1'b0);
          1: begin
            add_byte(SYNC_A, 1'b0);
            do tail = 8'($urandom_range(0, 255)); while (tail == SYNC_B);
            add_byte(tail, 1'b0);
          end
          default: begin
            add_byte(SYNC_A, 1'b0);
            add_byte(SYNC_B, 1'b0);
            do tail = 8'($urandom_range(0, 255)); while (tail == SYNC_C);
            add_byte(tail, 1'b0);
          end
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0:       id = ID_REQUEST;
          1:       id = ID_ACK;
          default: id = 8'($urandom_range(0, 255));
        endcase
        pick = $urandom_range(0, 99);
        if (!big_done && random_bytes_queued > RANDOM_BYTES / 2) begin
          len = 8'd255;
          big_done = 1'b1;
        end else if (pick < 87) begin
          len = 8'($urandom_range(0, 8));
        end else begin
          len = 8'($urandom_range(9, 40));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          ending = END_NO_CR;
          do tail = 8'($urandom_range(0, 255)); while (tail == BYTE_CR);
        end else if (pick == 1) begin
          ending = END_BAD_LF;
          do tail = 8'($urandom_range(0, 255)); while (tail == BYTE_LF);
        end else begin
          ending = END_CLEAN;
          tail = 8'h00;
        end
        add_frame(id, 16'($urandom_range(0, 65535)), len, ending, tail,
                  random_bytes_queued == 0 || $urandom_range(0, 11) == 0);
      end
      random_bytes_queued += rx_stream.size() - before_cnt;
    end

    // Hold reset, then release it on a rising edge.
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    // Wait for the last byte to go out and every result to come back.
    do @(negedge clk_i); while (rx_stream.size() != 0 || rx_ch.valid);
    do @(negedge clk_i); while (results_predicted != results_checked);
    repeat (6) @(negedge clk_i);

    $display("Sent %0d bytes in %0d queued frames plus noise, %0d results checked.",
             bytes_sent, frames_queued, results_checked);
    $display("Results: %0d body bytes, %0d commits, %0d aborts; %0d data frames counted.",
             body_seen, commits_seen, aborts_seen, data_frames);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
